FILE: hdl/nfcufc_pkg.sv
`timescale 1ns / 1ps

package nfcufc_pkg;

    // Frame layout
    localparam int HDR_LEN             = 6;
    localparam int MAX_FRAME_BYTES_DEF = 262;
    localparam int CAP_W               = 9;
    localparam int POS_W               = 9;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_FF   = 8'hFF;

    typedef enum logic [2:0] {
        ST_DATA_OK  = 3'd0,
        ST_ACK      = 3'd1,
        ST_NACK     = 3'd2,
        ST_LEN_ERR  = 3'd3,
        ST_DATA_ERR = 3'd4,
        ST_TRUNC    = 3'd5,
        ST_TIMEOUT  = 3'd6
    } frame_status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       timed_out;
    } rx_beat_t;

    typedef struct packed {
        logic          data_valid;
        logic [7:0]    data_byte;
        logic          frame_end;
        frame_status_t frame_status;
    } res_beat_t;

    typedef logic [CAP_W-1:0] cap_t;

endpackage

FILE: hdl/nfc_stream_if.sv
`timescale 1ns / 1ps

interface nfc_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/nfcufc_parser.sv
`timescale 1ns / 1ps

module nfcufc_parser
    import nfcufc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  rx_beat_t         beat,
    input  logic [CAP_W-1:0] room,
    output res_beat_t        result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [POS_W-1:0] rem_reg, rem_next;
    logic [7:0]       sum_reg, sum_next;
    logic             trunc_reg, trunc_next;
    logic [7:0]       hdr_reg [0:HDR_LEN-2];

    logic [7:0]       b;
    logic [7:0]       hdr_len;
    logic [7:0]       hdr_lcs;
    logic [7:0]       lcs_sum;
    logic [POS_W-1:0] need;
    logic             need_over;
    logic [POS_W-1:0] need_eff;
    logic             is_sync;
    logic             is_ack;
    logic             is_nack;
    logic [7:0]       sum_add;
    logic             clear;

    assign b         = beat.rx_byte;
    assign hdr_len   = hdr_reg[3];
    assign hdr_lcs   = hdr_reg[4];
    assign lcs_sum   = hdr_len + hdr_lcs;
    assign need      = {1'b0, hdr_len} + POS_W'(1);
    assign need_over = need > POS_W'(room);
    assign need_eff  = need_over ? POS_W'(room) : need;
    assign is_sync   = (hdr_reg[0] == BYTE_ZERO) && (hdr_reg[1] == BYTE_ZERO)
                    && (hdr_reg[2] == BYTE_FF);
    assign is_ack    = is_sync && (hdr_reg[3] == BYTE_ZERO) && (hdr_reg[4] == BYTE_FF)
                    && (b == BYTE_ZERO);
    assign is_nack   = is_sync && (hdr_reg[3] == BYTE_FF) && (hdr_reg[4] == BYTE_ZERO)
                    && (b == BYTE_ZERO);
    assign sum_add   = sum_reg + b;

    always_comb
    begin
        result     = '0;
        pos_next   = pos_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        sum_next   = sum_reg;
        trunc_next = trunc_reg;
        clear      = 1'b0;

        priority if (beat.timed_out)
        begin
            result.frame_end    = 1'b1;
            result.frame_status = ST_TIMEOUT;
            clear               = 1'b1;
        end
        else if (pos_reg < POS_W'(HDR_LEN - 1))
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else if (pos_reg == POS_W'(HDR_LEN - 1))
        begin
            priority if (is_ack)
            begin
                result.frame_end    = 1'b1;
                result.frame_status = ST_ACK;
                clear               = 1'b1;
            end
            else if (is_nack)
            begin
                result.frame_end    = 1'b1;
                result.frame_status = ST_NACK;
                clear               = 1'b1;
            end
            else if (lcs_sum != 8'd0)
            begin
                result.frame_end    = 1'b1;
                result.frame_status = ST_LEN_ERR;
                clear               = 1'b1;
            end
            else
            begin
                // First payload byte (TFI) opens the running sum
                if (hdr_len != 8'd0)
                begin
                    result.data_valid = 1'b1;
                    result.data_byte  = b;
                end
                if (need_eff == '0)
                begin
                    result.frame_end    = 1'b1;
                    result.frame_status = ST_TRUNC;
                    clear               = 1'b1;
                end
                else
                begin
                    pos_next   = pos_reg + POS_W'(1);
                    len_next   = hdr_len;
                    rem_next   = need_eff;
                    sum_next   = b;
                    trunc_next = need_over;
                end
            end
        end
        else
        begin
            if (pos_reg <= ({1'b0, len_reg} + POS_W'(HDR_LEN - 2)))
            begin
                result.data_valid = 1'b1;
                result.data_byte  = b;
            end
            if (pos_reg <= ({1'b0, len_reg} + POS_W'(HDR_LEN - 1)))
            begin
                sum_next = sum_add;
            end
            pos_next = pos_reg + POS_W'(1);
            rem_next = rem_reg - POS_W'(1);
            if (rem_reg <= POS_W'(1))
            begin
                result.frame_end = 1'b1;
                if (trunc_reg)
                begin
                    result.frame_status = ST_TRUNC;
                end
                else if (sum_next == 8'd0)
                begin
                    result.frame_status = ST_DATA_OK;
                end
                else
                begin
                    result.frame_status = ST_DATA_ERR;
                end
                clear = 1'b1;
            end
        end

        if (clear)
        begin
            pos_next   = '0;
            len_next   = '0;
            rem_next   = '0;
            sum_next   = '0;
            trunc_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            sum_reg   <= '0;
            trunc_reg <= 1'b0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            sum_reg   <= sum_next;
            trunc_reg <= trunc_next;
        end
    end

    // Header bytes are only read once all five have been written in this frame
    always_ff @(posedge clk)
    begin
        if (take && !beat.timed_out && (pos_reg < POS_W'(HDR_LEN - 1)))
        begin
            hdr_reg[pos_reg[2:0]] <= b;
        end
    end

endmodule

FILE: hdl/nfc_uart_frame_checker.sv
`timescale 1ns / 1ps

// Response frame checker for a contactless-reader controller on a UART link.
// Each beat on rx carries one received byte or a timeout mark; each accepted
// beat yields exactly one beat on res, from a result register.
// rx accepts whenever that register is empty or is being drained in the same
// cycle, so the block sustains one byte per clock; while res stalls with the
// register full, rx stalls with it. The first six bytes
// form the header: the ACK and NACK frames end there, otherwise LEN and LCS
// are checked and LEN+1 further bytes are taken (payload, DCS, postamble),
// limited by the buffer capacity written on cfg. Payload bytes come out with
// data_valid set; frame_end with frame_status marks the beat that finishes or
// aborts a frame. A capacity below 6 acts as 6 and one above MAX_FRAME_BYTES
// acts as MAX_FRAME_BYTES. Write cfg only while no frame is in progress and
// res is empty. No clearing pass: the block is ready straight out of reset.

module nfc_uart_frame_checker
    import nfcufc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    nfc_stream_if.sink   rx,
    nfc_stream_if.source res,
    nfc_stream_if.sink   cfg
);

    localparam cap_t ROOM_MAX = cap_t'(MAX_FRAME_BYTES - HDR_LEN);

    // Room after the header, clamped once when the capacity is written
    cap_t      room_reg, room_next;
    logic      out_valid_reg;
    res_beat_t out_beat_reg;
    res_beat_t beat_res;
    logic      take;
    cap_t      cap_wr;

    assign cfg.ready = 1'b1;
    assign cap_wr    = cap_t'(cfg.payload);

    always_comb
    begin
        priority if (cap_wr < cap_t'(HDR_LEN))
        begin
            room_next = '0;
        end
        else if (cap_wr > cap_t'(MAX_FRAME_BYTES))
        begin
            room_next = ROOM_MAX;
        end
        else
        begin
            room_next = cap_wr - cap_t'(HDR_LEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_reg <= ROOM_MAX;
        end
        else if (cfg.valid && cfg.ready)
        begin
            room_reg <= room_next;
        end
    end

    // Accept a new byte whenever the result register is empty or drains now
    assign rx.ready = !out_valid_reg || res.ready;
    assign take     = rx.valid && rx.ready;

    nfcufc_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .beat   (rx.payload),
        .room   (room_reg),
        .result (beat_res)
    );

    // Result register: load on each accepted beat, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_beat_reg <= beat_res;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = out_beat_reg;

    // A status other than data ok only travels with frame_end
    a_status_with_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_beat_reg.frame_end |-> out_beat_reg.frame_status == ST_DATA_OK)
        else $error("frame status set without frame end");

    // A timeout beat ends the frame on the next result
    a_timeout_ends: assert property (@(posedge clk) disable iff (!rst_n)
        take && rx.payload.timed_out |=>
            out_valid_reg && out_beat_reg.frame_end && !out_beat_reg.data_valid
            && out_beat_reg.frame_status == ST_TIMEOUT)
        else $error("timeout did not end the frame");

    // Data byte is zero unless it carries payload
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_beat_reg.data_valid |-> out_beat_reg.data_byte == 8'd0)
        else $error("data byte set without data valid");

    // Room never exceeds the buffer limit
    a_room_range: assert property (@(posedge clk) disable iff (!rst_n)
        room_reg <= ROOM_MAX)
        else $error("room out of range");

endmodule
